// ===== rtl/core/wrsp_pkg.sv =====
package wrsp_pkg;

   typedef enum logic [3:0] {
      PH_RIFF  = 4'd0,
      PH_SIZE  = 4'd1,
      PH_WAVE  = 4'd2,
      PH_ID    = 4'd3,
      PH_LEN   = 4'd4,
      PH_FMT   = 4'd5,
      PH_DATA  = 4'd6,
      PH_SKIP  = 4'd7,
      PH_DRAIN = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_FORMAT = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   localparam logic [2:0] ERR_BAD_RIFF   = 3'd0;
   localparam logic [2:0] ERR_BAD_WAVE   = 3'd1;
   localparam logic [2:0] ERR_COMPRESSED = 3'd2;
   localparam logic [2:0] ERR_CHANNELS   = 3'd3;
   localparam logic [2:0] ERR_DEPTH      = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd5;
   localparam logic [2:0] ERR_FMT_SIZE   = 3'd6;

   localparam logic [1:0] DEPTH_8  = 2'd0;
   localparam logic [1:0] DEPTH_16 = 2'd1;
   localparam logic [1:0] DEPTH_32 = 2'd2;

   // tags as little-endian words
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam int unsigned FMT_CHUNK_LENGTH = 16;
   localparam logic [15:0] FORMAT_PCM       = 16'd1;
   localparam logic [15:0] CHANNELS_MONO    = 16'd1;
   localparam logic [15:0] CHANNELS_STEREO  = 16'd2;
   localparam logic [15:0] BITS_8           = 16'd8;
   localparam logic [15:0] BITS_16          = 16'd16;
   localparam logic [15:0] BITS_32          = 16'd32;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  sample_byte;
      logic        stereo;
      logic [31:0] sample_rate;
      logic [1:0]  depth_code;
      logic [2:0]  error_code;
      logic [31:0] total_bytes;
      logic        last;
   } result_type;

   // one accepted request: an optional result plus an optional done result
   typedef struct packed {
      logic        main_valid;
      result_type  main;
      logic        done_valid;
      logic [31:0] total;
   } entry_type;

endpackage

// ===== rtl/core/wrsp_front.sv =====
module wrsp_front
   import wrsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  logic [7:0] in_byte,
   input  logic      in_last,
   input  logic      queue_full,
   output logic      entry_valid,
   output entry_type entry
);

   localparam logic [3:0] POS_FORMAT   = 4'd1;
   localparam logic [3:0] POS_CHANNELS = 4'd3;
   localparam logic [3:0] POS_RATE     = 4'd7;
   localparam logic [3:0] POS_BITS     = 4'd15;

   phase_type              phase_ff, phase_in, phase_step;
   logic [3:0]             count_ff, count_in, count_step;
   logic [31:0]            word_ff, word_in;
   logic                   is_fmt_ff, is_fmt_in;
   logic                   is_data_ff, is_data_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   stereo_ff, stereo_in;
   logic [31:0]            rate_ff, rate_in;
   logic [1:0]             depth_ff, depth_in;
   logic [31:0]            total_ff, total_in, total_step;

   logic                   fire;
   logic [31:0]            word_full;
   logic [15:0]            half;
   logic                   header;
   logic                   word_done;
   logic                   wide;
   logic                   field_end;
   logic [LENGTH_BITS-1:0] len_val;
   logic                   length_last;
   logic                   fail;
   logic [2:0]             fail_code;
   logic [1:0]             depth_sel;
   logic                   format_emit;
   logic                   data_emit;
   logic                   clean;
   logic                   truncated;

   assign in_ready = !queue_full;
   assign fire     = in_valid && in_ready;

   // decode of the incoming byte against the current phase
   always_comb begin
      word_full   = {in_byte, word_ff[31:8]};
      half        = {in_byte, word_ff[31:24]};
      header      = (phase_ff == PH_RIFF) || (phase_ff == PH_SIZE) || (phase_ff == PH_WAVE) ||
                    (phase_ff == PH_ID) || (phase_ff == PH_LEN);
      word_done   = header && (count_ff[1:0] == 2'd3);
      wide        = (count_ff >= 4'd4) && (count_ff < 4'd12);
      field_end   = wide ? (count_ff[1:0] == 2'd3) : count_ff[0];
      len_val     = word_full[LENGTH_BITS-1:0];
      length_last = (length_ff == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
      if (half == BITS_8) begin
         depth_sel = DEPTH_8;
      end else if (half == BITS_16) begin
         depth_sel = DEPTH_16;
      end else begin
         depth_sel = DEPTH_32;
      end
      fail      = 1'b0;
      fail_code = ERR_BAD_RIFF;
      if (fire) begin
         unique case (phase_ff)
            PH_RIFF: begin
               if (word_done && (word_full != TAG_RIFF)) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_RIFF;
               end
            end
            PH_WAVE: begin
               if (word_done && (word_full != TAG_WAVE)) begin
                  fail      = 1'b1;
                  fail_code = ERR_BAD_WAVE;
               end
            end
            PH_LEN: begin
               if (word_done && is_fmt_ff &&
                   (len_val != LENGTH_BITS'(FMT_CHUNK_LENGTH))) begin
                  fail      = 1'b1;
                  fail_code = ERR_FMT_SIZE;
               end
            end
            PH_FMT: begin
               if (field_end && (count_ff == POS_FORMAT) && (half != FORMAT_PCM)) begin
                  fail      = 1'b1;
                  fail_code = ERR_COMPRESSED;
               end
               if (field_end && (count_ff == POS_CHANNELS) &&
                   (half != CHANNELS_MONO) && (half != CHANNELS_STEREO)) begin
                  fail      = 1'b1;
                  fail_code = ERR_CHANNELS;
               end
               if (field_end && (count_ff == POS_BITS) &&
                   (half != BITS_8) && (half != BITS_16) && (half != BITS_32)) begin
                  fail      = 1'b1;
                  fail_code = ERR_DEPTH;
               end
            end
            default: begin
               fail = 1'b0;
            end
         endcase
      end
      format_emit = fire && (phase_ff == PH_FMT) && field_end && (count_ff == POS_BITS) && !fail;
      data_emit   = fire && (phase_ff == PH_DATA);
   end

   // next state
   always_comb begin
      phase_step = phase_ff;
      count_step = count_ff;
      word_in    = word_ff;
      is_fmt_in  = is_fmt_ff;
      is_data_in = is_data_ff;
      length_in  = length_ff;
      stereo_in  = stereo_ff;
      rate_in    = rate_ff;
      depth_in   = depth_ff;
      total_step = total_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_RIFF, PH_SIZE, PH_WAVE, PH_ID, PH_LEN: begin
               word_in    = word_full;
               count_step = {2'b00, count_ff[1:0] + 2'd1};
               if (word_done) begin
                  unique case (phase_ff)
                     PH_RIFF: phase_step = PH_SIZE;
                     PH_SIZE: phase_step = PH_WAVE;
                     PH_WAVE: phase_step = PH_ID;
                     PH_ID: begin
                        is_fmt_in  = (word_full == TAG_FMT);
                        is_data_in = (word_full == TAG_DATA);
                        phase_step = PH_LEN;
                     end
                     default: begin
                        if (is_fmt_ff) begin
                           phase_step = PH_FMT;
                        end else if (len_val == '0) begin
                           phase_step = PH_ID;
                        end else begin
                           length_in  = len_val;
                           phase_step = is_data_ff ? PH_DATA : PH_SKIP;
                        end
                     end
                  endcase
               end
            end
            PH_FMT: begin
               word_in    = word_full;
               count_step = count_ff + 4'd1;
               if (field_end && (count_ff == POS_CHANNELS)) begin
                  stereo_in = half[1];
               end
               if (field_end && (count_ff == POS_RATE)) begin
                  rate_in = word_full;
               end
               if (field_end && (count_ff == POS_BITS)) begin
                  depth_in   = depth_sel;
                  phase_step = PH_ID;
                  count_step = 4'd0;
               end
            end
            PH_DATA: begin
               total_step = total_ff + 32'd1;
               length_in  = length_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               if (length_last) begin
                  phase_step = PH_ID;
               end
            end
            PH_SKIP: begin
               length_in = length_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               if (length_last) begin
                  phase_step = PH_ID;
               end
            end
            default: begin
               phase_step = phase_ff;
            end
         endcase
         if (fail) begin
            phase_step = PH_DRAIN;
         end
      end
      // rearm after the end-of-file request
      phase_in = phase_step;
      count_in = count_step;
      total_in = total_step;
      if (fire && in_last) begin
         phase_in = PH_RIFF;
         count_in = 4'd0;
         total_in = 32'd0;
      end
   end

   // result entry for the queue
   always_comb begin
      clean       = ((phase_step == PH_ID) && (count_step == 4'd0)) ||
                    (phase_step == PH_DATA) || (phase_step == PH_SKIP);
      truncated   = fire && in_last && (phase_step != PH_DRAIN) && !clean;
      entry       = '0;
      entry.total = total_step;
      if (fail) begin
         entry.main_valid      = 1'b1;
         entry.main.kind       = KIND_ERROR;
         entry.main.error_code = fail_code;
      end else if (data_emit) begin
         entry.main_valid       = 1'b1;
         entry.main.kind        = KIND_DATA;
         entry.main.sample_byte = in_byte;
      end else if (format_emit) begin
         entry.main_valid       = 1'b1;
         entry.main.kind        = KIND_FORMAT;
         entry.main.stereo      = stereo_ff;
         entry.main.sample_rate = rate_ff;
         entry.main.depth_code  = depth_sel;
      end else if (truncated) begin
         entry.main_valid      = 1'b1;
         entry.main.kind       = KIND_ERROR;
         entry.main.error_code = ERR_TRUNCATED;
      end
      entry.done_valid = fire && in_last;
      entry_valid      = fire && (entry.main_valid || entry.done_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         count_ff <= 4'd0;
         total_ff <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      is_fmt_ff  <= is_fmt_in;
      is_data_ff <= is_data_in;
      length_ff  <= length_in;
      stereo_ff  <= stereo_in;
      rate_ff    <= rate_in;
      depth_ff   <= depth_in;
   end

   a_drain_reports_error: assert property (@(posedge clock) disable iff (reset)
      (fire && (phase_step == PH_DRAIN) && (phase_ff != PH_DRAIN)) |->
      (entry_valid && entry.main_valid && (entry.main.kind == KIND_ERROR)))
      else $error("error phase entered without an error result");

endmodule

// ===== rtl/core/wrsp_queue.sv =====
module wrsp_queue
   import wrsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

// ===== rtl/core/wrsp_back.sv =====
module wrsp_back
   import wrsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  entry_type  head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   entry_type cur_ff, cur_in;
   logic      main_pend_ff, main_pend_in;
   logic      done_pend_ff, done_pend_in;
   logic      fire;
   logic      main_left;
   logic      done_left;

   assign out_valid = main_pend_ff || done_pend_ff;
   assign fire      = out_valid && out_ready;

   always_comb begin
      out_result = '0;
      if (main_pend_ff) begin
         out_result = cur_ff.main;
      end else begin
         out_result.kind        = KIND_DONE;
         out_result.total_bytes = cur_ff.total;
         out_result.last        = 1'b1;
      end
   end

   // send the main result first, then the done result; refill as the last one goes
   always_comb begin
      main_left    = main_pend_ff && !fire;
      done_left    = done_pend_ff && !(fire && !main_pend_ff);
      pop          = not_empty && !main_left && !done_left;
      cur_in       = cur_ff;
      main_pend_in = main_left;
      done_pend_in = done_left;
      if (pop) begin
         cur_in       = head;
         main_pend_in = head.main_valid;
         done_pend_in = head.done_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_pend_ff <= 1'b0;
         done_pend_ff <= 1'b0;
      end else begin
         main_pend_ff <= main_pend_in;
         done_pend_ff <= done_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_pop_has_work: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head.main_valid || head.done_valid))
      else $error("queue entry carries no result");

endmodule

// ===== rtl/core/wav_riff_stream_parser.sv =====
// WAV (RIFF/WAVE, PCM) header parser and payload extractor.
// Request channel (req_*): one file byte per request in req_tdata, req_tlast on the
// final byte of the file. Result channel (rsp_*): rsp_tuser gives the kind (data byte,
// format info, done, error), rsp_tdata the fields, rsp_tlast marks the done result.
// A front stage decodes each byte against the header/chunk state and writes at most
// one queue entry (an optional result plus an optional done result). A back stage
// drains the four-entry queue into the output register.
// Throughput: one request per cycle while the queue is not full. A data byte gives
// one result per cycle while the receiver is ready; a last byte that also yields a
// data byte, format info or an error gives two results, the main one, then the done
// one. Each result is written to the queue, then moved into the output register.
// When the receiver stalls, the output holds and the queue fills; req_tready drops
// while the queue is full. After an error the block drops bytes until req_tlast.
// Reset (synchronous) empties the queue and the output and expects a RIFF tag next;
// each last byte also rearms the parser for a new file.
module wav_riff_stream_parser
   import wrsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // sample_byte, stereo, sample_rate, depth_code,
                                    // error_code, total_bytes, zero fill
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   logic       push;
   entry_type  push_entry;
   logic       full;
   logic       pop;
   logic       not_empty;
   entry_type  head;
   result_type result;

   wrsp_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (full),
      .entry_valid(push),
      .entry      (push_entry)
   );

   wrsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   wrsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_result(result)
   );

   assign rsp_tdata = {2'b00, result.total_bytes, result.error_code, result.depth_code,
                       result.sample_rate, result.stereo, result.sample_byte};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   import wrsp_pkg::*;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int          LEN_BITS      = 32;
   localparam logic [31:0] LENGTH_MASK   = 32'((64'd1 << LEN_BITS) - 64'd1);
   localparam int          HOLD_CYCLES   = 64;
   localparam int          BYTES_PER_MODE = 200;
   localparam int          DRAIN_CYCLES  = 16;

   // fmt chunk faults injected by the file builder
   localparam int FAULT_SIZE     = 0;
   localparam int FAULT_FORMAT   = 1;
   localparam int FAULT_CHANNELS = 2;
   localparam int FAULT_DEPTH    = 3;

   class wav_parse_scoreboard;
      phase_type   parse_phase;
      logic [31:0] byte_pos;
      logic [31:0] bytes_left;
      logic [31:0] word_acc;
      logic [31:0] chunk_id;
      logic [31:0] rate_acc;
      logic [31:0] payload_count;
      logic        is_stereo;
      logic        error_flag;
      logic [1:0]  depth_sel;
      result_type  awaited[$];
      int          failures;

      function new();
         failures = 0;
         rearm();
      endfunction

      function void rearm();
         parse_phase   = PH_RIFF;
         byte_pos      = '0;
         bytes_left    = '0;
         word_acc      = '0;
         chunk_id      = '0;
         rate_acc      = '0;
         payload_count = '0;
         is_stereo     = 1'b0;
         error_flag    = 1'b0;
         depth_sel     = DEPTH_8;
      endfunction

      function void push_result(kind_type k, logic [7:0] sb, logic st, logic [31:0] rate,
                                logic [1:0] dep, logic [2:0] code, logic [31:0] tot,
                                logic lst);
         result_type r;
         r.kind        = k;
         r.sample_byte = sb;
         r.stereo      = st;
         r.sample_rate = rate;
         r.depth_code  = dep;
         r.error_code  = code;
         r.total_bytes = tot;
         r.last        = lst;
         awaited.push_back(r);
      endfunction

      function void raise_error(logic [2:0] code);
         error_flag  = 1'b1;
         parse_phase = PH_DRAIN;
         push_result(KIND_ERROR, '0, 1'b0, '0, '0, code, '0, 1'b0);
      endfunction

      // advance the parser by one accepted request and queue what it yields
      function void note_byte(logic [7:0] b, logic eof);
         logic [31:0] w;
         logic [31:0] len;
         logic [3:0]  p;
         logic        wide;
         logic        ends;
         logic        clean;
         int          sh;
         if (parse_phase <= PH_LEN) begin
            word_acc |= 32'(b) << (8 * byte_pos[1:0]);
            byte_pos = (byte_pos + 32'd1) & 32'd3;
            if (byte_pos == 0) begin
               w = word_acc;
               word_acc = '0;
               case (parse_phase)
                  PH_RIFF: begin
                     if (w != TAG_RIFF) raise_error(ERR_BAD_RIFF);
                     else parse_phase = PH_SIZE;
                  end
                  PH_SIZE: parse_phase = PH_WAVE;
                  PH_WAVE: begin
                     if (w != TAG_WAVE) raise_error(ERR_BAD_WAVE);
                     else parse_phase = PH_ID;
                  end
                  PH_ID: begin
                     chunk_id = w;
                     parse_phase = PH_LEN;
                  end
                  default: begin
                     len = w & LENGTH_MASK;
                     if (chunk_id == TAG_FMT) begin
                        if (len != FMT_CHUNK_LENGTH) raise_error(ERR_FMT_SIZE);
                        else begin
                           parse_phase = PH_FMT;
                           byte_pos = '0;
                        end
                     end else if (len == 0) begin
                        parse_phase = PH_ID;
                     end else begin
                        bytes_left = len;
                        if (chunk_id == TAG_DATA) parse_phase = PH_DATA;
                        else parse_phase = PH_SKIP;
                     end
                  end
               endcase
            end
         end else if (parse_phase == PH_FMT) begin
            // 16-bit fields except rate and byte rate, which are 32 bits wide
            p = byte_pos[3:0];
            wide = (p >= 4'd4) && (p < 4'd12);
            sh = wide ? 8 * p[1:0] : 8 * p[0];
            ends = wide ? (p[1:0] == 2'd3) : p[0];
            word_acc |= 32'(b) << sh;
            byte_pos = 32'(p) + 32'd1;
            if (ends) begin
               w = word_acc;
               word_acc = '0;
               case (p)
                  4'd1: if (w != 32'(FORMAT_PCM)) raise_error(ERR_COMPRESSED);
                  4'd3: begin
                     if (w == 32'(CHANNELS_MONO)) is_stereo = 1'b0;
                     else if (w == 32'(CHANNELS_STEREO)) is_stereo = 1'b1;
                     else raise_error(ERR_CHANNELS);
                  end
                  4'd7: rate_acc = w;
                  4'd15: begin
                     if (w == 32'(BITS_8)) depth_sel = DEPTH_8;
                     else if (w == 32'(BITS_16)) depth_sel = DEPTH_16;
                     else if (w == 32'(BITS_32)) depth_sel = DEPTH_32;
                     else raise_error(ERR_DEPTH);
                     if (!error_flag) begin
                        push_result(KIND_FORMAT, '0, is_stereo, rate_acc, depth_sel, '0, '0,
                                    1'b0);
                        parse_phase = PH_ID;
                        byte_pos = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end else if (parse_phase == PH_DATA) begin
            push_result(KIND_DATA, b, 1'b0, '0, '0, '0, '0, 1'b0);
            payload_count += 32'd1;
            bytes_left -= 32'd1;
            if (bytes_left == 0) parse_phase = PH_ID;
         end else if (parse_phase == PH_SKIP) begin
            bytes_left -= 32'd1;
            if (bytes_left == 0) parse_phase = PH_ID;
         end

         if (eof) begin
            clean = (parse_phase == PH_ID && byte_pos == 0) ||
                    parse_phase == PH_DATA || parse_phase == PH_SKIP;
            if (!error_flag && !clean) raise_error(ERR_TRUNCATED);
            push_result(KIND_DONE, '0, 1'b0, '0, '0, '0, payload_count, 1'b1);
            rearm();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            $error("kind: expected nothing, got %0h", got.kind);
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("sample_byte", want.sample_byte, got.sample_byte);
         compare_field("stereo", want.stereo, got.stereo);
         compare_field("sample_rate", want.sample_rate, got.sample_rate);
         compare_field("depth_code", want.depth_code, got.depth_code);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("total_bytes", want.total_bytes, got.total_bytes);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   wav_parse_scoreboard sb;
   idle_mode_type       idle_mode = IDLE_NONE;
   int                  hold_requests = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   result_type          seen;

   wav_riff_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: check each accepted result, then decide the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind        = kind_type'(rsp_tuser);
         seen.sample_byte = rsp_tdata[7:0];
         seen.stereo      = rsp_tdata[8];
         seen.sample_rate = rsp_tdata[40:9];
         seen.depth_code  = rsp_tdata[42:41];
         seen.error_code  = rsp_tdata[45:43];
         seen.total_bytes = rsp_tdata[77:46];
         seen.last        = rsp_tlast;
         sb.check_result(seen);
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_tready <= ($urandom_range(0, 99) >= 73);
            IDLE_BOTH:     rsp_tready <= ($urandom_range(0, 99) >= 35);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   function automatic void put_field(ref logic [7:0] f[$], input logic [31:0] w, input int n);
      for (int i = 0; i < n; i++) f.push_back(w[8*i +: 8]);
   endfunction

   function automatic void push_noise(ref logic [7:0] f[$], input int n);
      repeat (n) f.push_back(8'($urandom_range(0, 255)));
   endfunction

   // build one file: mostly well-formed with random content, some faults and noise
   function automatic void make_file(ref logic [7:0] f[$]);
      int          pick;
      int          fault;
      int          nchunks;
      int          n;
      logic [31:0] w;
      logic [31:0] len;
      bit          cut;
      f.delete();
      if ($urandom_range(0, 19) == 0) begin
         push_noise(f, $urandom_range(1, 8));
         return;
      end
      w = TAG_RIFF;
      if ($urandom_range(0, 19) == 0) w ^= 32'd1 << $urandom_range(0, 31);
      put_field(f, w, 4);
      put_field(f, $urandom, 4);
      w = TAG_WAVE;
      if ($urandom_range(0, 19) == 0) w ^= 32'd1 << $urandom_range(0, 31);
      put_field(f, w, 4);
      nchunks = $urandom_range(1, 3);
      cut = 0;
      for (int c = 0; c < nchunks && !cut; c++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            fault = $urandom_range(0, 7);
            len = FMT_CHUNK_LENGTH;
            if (fault == FAULT_SIZE)
               len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 15));
            put_field(f, TAG_FMT, 4);
            put_field(f, len, 4);
            put_field(f, (fault == FAULT_FORMAT) ? $urandom_range(2, 65535) : 32'(FORMAT_PCM), 2);
            if (fault == FAULT_CHANNELS) begin
               w = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom_range(3, 65535);
               put_field(f, w, 2);
            end else begin
               put_field(f, $urandom_range(1, 2), 2);
            end
            case ($urandom_range(0, 3))
               0:       w = 32'd0;
               1:       w = 32'hFFFF_FFFF;
               2:       w = 32'd44100;
               default: w = $urandom;
            endcase
            put_field(f, w, 4);
            put_field(f, $urandom, 4);
            put_field(f, $urandom, 2);
            n = $urandom_range(0, 2);
            w = (n == 0) ? 32'(BITS_8) : (n == 1) ? 32'(BITS_16) : 32'(BITS_32);
            if (fault == FAULT_DEPTH) w = ($urandom_range(0, 1) != 0) ? 32'd24 : $urandom_range(0, 65535);
            put_field(f, w, 2);
         end else if (pick < 7) begin
            put_field(f, TAG_DATA, 4);
            if ($urandom_range(0, 15) == 0) begin
               // huge length: the file ends inside the payload
               len = $urandom | 32'h8000_0000;
               n = $urandom_range(0, 10);
               cut = 1;
            end else begin
               len = $urandom_range(0, 10);
               n = len;
            end
            put_field(f, len, 4);
            push_noise(f, n);
         end else if (pick < 9) begin
            w = $urandom;
            if (w == TAG_FMT || w == TAG_DATA) w ^= 32'd1;
            len = $urandom_range(0, 6);
            put_field(f, w, 4);
            put_field(f, len, 4);
            push_noise(f, len);
         end else begin
            // stop inside a chunk id or length
            push_noise(f, $urandom_range(1, 7));
            cut = 1;
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, f.size());
         while (f.size() > n) void'(f.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 73) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 35)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, eof);
   endtask

   task automatic send_file(ref logic [7:0] f[$]);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   // drop the request and wait until every expected result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [7:0] f[$];
      int         sent;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a lone byte marked last: truncated header
      f = '{8'h00};
      send_file(f);
      // bad RIFF tag on the last byte: error and done on one request
      f = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_file(f);
      // bad WAVE tag, size field at its maximum
      f.delete();
      put_field(f, TAG_RIFF, 4);
      put_field(f, 32'hFFFF_FFFF, 4);
      put_field(f, TAG_WAVE ^ 32'h8000_0000, 4);
      send_file(f);

      for (int m = 0; m < 4; m++) begin
         // hold off the next request until all results are back
         wait_for_results();
         idle_mode = idle_mode_type'(m);
         if (idle_mode == IDLE_NONE) hold_requests++;
         sent = 0;
         while (sent < BYTES_PER_MODE) begin
            make_file(f);
            send_file(f);
            sent += f.size();
         end
      end
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.awaited.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wrsp_pkg.sv
rtl/core/wrsp_front.sv
rtl/core/wrsp_queue.sv
rtl/core/wrsp_back.sv
rtl/core/wav_riff_stream_parser.sv
verif/tb_top.sv
